### design/hchb_pkg.sv
// shared types, constants and register codes for the hexagon height binning block
package hchb_pkg;

    localparam int TABLE_COLUMNS   = 64;
    localparam int TABLE_HALF_ROWS = 128;
    localparam int COL_BITS        = $clog2(TABLE_COLUMNS);
    localparam int HR_BITS         = $clog2(TABLE_HALF_ROWS);
    localparam int IDX_BITS        = COL_BITS + HR_BITS;
    localparam int DEPTH           = TABLE_COLUMNS * TABLE_HALF_ROWS;

    // register indexes
    localparam logic [2:0] REG_CELL_LENGTH = 3'd0;
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd1;
    localparam logic [2:0] REG_THRESHOLD   = 3'd2;
    localparam logic [2:0] REG_COL_OFFSET  = 3'd3;
    localparam logic [2:0] REG_ROW_OFFSET  = 3'd4;

    typedef struct packed {
        logic [15:0] cell_length;
        logic [15:0] cell_width;
        logic [15:0] height_threshold;
        logic [7:0]  column_offset;
        logic [7:0]  row_offset;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic clr;        // clear one frame tag entry
        logic load;       // capture input word, start dividers
        logic div_step;   // one restoring step on both quotients
        logic div_fix;    // floor correction
        logic cand;       // form candidates
        logic meas;       // compute distances (one candidate)
        logic [1:0] dsel; // candidate being measured
        logic rd;         // issue table read
        logic upd;        // merge and write back
        logic frame;      // toggle frame tag
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic in_table;
    } stat_t;

endpackage

### design/hex_cell_height_binning_top.sv
// top level: stream ports, configuration registers, controller and datapath
// one point in flight; a point off the table skips the table wait and write-back
// pace: set by the 20 step restoring dividers and the single port table
//   read-modify-write, plus output stalls
// reset: rst_n clears control state and configuration registers at once, then a pass
//   over all 8192 table entries clears the frame tags with s_tready low
module hex_cell_height_binning_top import hchb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // point_x, point_y, point_z from bit 0
    input  logic        s_tuser,  // new_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // in_region, cell_column, cell_half_row,
                                  // cell_top, cell_bottom, cell_count, obstacle
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  busy, out_load, mv_reg;
    logic [63:0] res, md_reg;
    logic [2:0]  ra;

    assign pready = 1'b1;
    assign ra     = paddr[4:2];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_length      <= 16'd192;
            cfg_reg.cell_width       <= 16'd222;
            cfg_reg.height_threshold <= 16'd26;
            cfg_reg.column_offset    <= 8'd32;
            cfg_reg.row_offset       <= 8'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (ra)
                REG_CELL_LENGTH: cfg_reg.cell_length      <= pwdata[15:0];
                REG_CELL_WIDTH:  cfg_reg.cell_width       <= pwdata[15:0];
                REG_THRESHOLD:   cfg_reg.height_threshold <= pwdata[15:0];
                REG_COL_OFFSET:  cfg_reg.column_offset    <= pwdata[7:0];
                REG_ROW_OFFSET:  cfg_reg.row_offset       <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (ra)
            REG_CELL_LENGTH: prdata = {16'd0, cfg_reg.cell_length};
            REG_CELL_WIDTH:  prdata = {16'd0, cfg_reg.cell_width};
            REG_THRESHOLD:   prdata = {16'd0, cfg_reg.height_threshold};
            REG_COL_OFFSET:  prdata = {24'd0, cfg_reg.column_offset};
            REG_ROW_OFFSET:  prdata = {24'd0, cfg_reg.row_offset};
            default:         prdata = 32'd0;
        endcase
    end

    assign s_tready = !busy;

    hchb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_tvalid && s_tready), .in_new_frame(s_tuser),
        .out_free(!mv_reg || m_tready), .stat(stat),
        .cmd(cmd), .busy(busy), .out_load(out_load));

    hchb_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg_reg),
        .px(s_tdata[19:0]), .py(s_tdata[39:20]), .pz(s_tdata[55:40]),
        .stat(stat), .res(res));

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
        end
        else if (out_load)
        begin
            mv_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            md_reg <= res;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
endmodule

### design/hchb_ram.sv
// generic single port ram with registered read
module hchb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### design/hchb_ctrl.sv
// sequencer for one point: divide, pick centre, table read-modify-write
module hchb_ctrl import hchb_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_fire,
    input  logic  in_new_frame,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  out_load
);
    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_DIV  = 11'b00000000100,
        S_FIX  = 11'b00000001000,
        S_CAND = 11'b00000010000,
        S_DIST = 11'b00000100000,
        S_PICK = 11'b00001000000,
        S_RD   = 11'b00010000000,
        S_WAIT = 11'b00100000000,
        S_UPD  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] d_reg, d_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            d_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            d_reg     <= d_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        d_next     = d_reg;
        cmd        = '0;
        cmd.dsel   = d_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    cmd.frame  = in_new_frame;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.div_fix = 1'b1;
                state_next  = S_CAND;
            end
            S_CAND:
            begin
                cmd.cand   = 1'b1;
                d_next     = 2'd0;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                cmd.meas = 1'b1;
                if (d_reg == 2'd2)
                begin
                    state_next = S_PICK;
                end
                d_next = d_reg + 2'd1;
            end
            S_PICK:
            begin
                // last square lands in the running minimum
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = stat.in_table ? S_WAIT : S_OUT;
            end
            S_WAIT:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

### design/hchb_dp.sv
// datapath: floor dividers, candidate distances, cell table and merge
module hchb_dp import hchb_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    input  cfg_t         cfg,
    input  logic [19:0]  px,
    input  logic [19:0]  py,
    input  logic [15:0]  pz,
    output stat_t        stat,
    output logic [63:0]  res
);
    // pitches, zero acts as one
    logic [15:0] len, wid;
    assign len = (cfg.cell_length == 16'd0) ? 16'd1 : cfg.cell_length;
    assign wid = (cfg.cell_width == 16'd0) ? 16'd1 : cfg.cell_width;

    logic signed [19:0] x_reg, y_reg;
    logic signed [15:0] z_reg;
    logic [19:0] qx_reg, qy_reg, ax_reg, ay_reg;
    logic [16:0] rx_reg, ry_reg;
    logic        nx_reg, ny_reg;
    logic [4:0]  cnt_reg;
    logic signed [20:0] cx_reg, cy_reg;
    logic signed [21:0] ccol_reg [3];
    logic signed [22:0] chr_reg [3];
    logic [1:0]  best_reg;
    logic [63:0] bestd_reg;
    logic signed [40:0] dx_reg, dy_reg;
    logic        dsq_v_reg;
    logic [1:0]  dsq_i_reg;
    logic        inreg_reg;
    logic [COL_BITS-1:0] tcol_reg;
    logic [HR_BITS-1:0]  thr_reg;
    logic        tag_cur_reg;
    logic [IDX_BITS-1:0] clr_reg;
    logic [15:0] top_o_reg, bot_o_reg, cnt_o_reg;
    logic        obs_reg;

    // magnitude for restoring division
    logic [19:0] mx, my;
    assign mx = px[19] ? (~px + 20'd1) : px;
    assign my = py[19] ? (~py + 20'd1) : py;

    // one restoring step on each quotient
    logic [16:0] trx, try_;
    logic [16:0] sx, sy;
    assign trx = {rx_reg[15:0], ax_reg[19]};
    assign try_ = {ry_reg[15:0], ay_reg[19]};
    assign sx  = trx - {1'b0, len};
    assign sy  = try_ - {1'b0, wid};

    assign stat.div_done = (cnt_reg == 5'd19);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= px;
            y_reg  <= py;
            z_reg  <= pz;
            ax_reg <= mx;
            ay_reg <= my;
            nx_reg <= px[19];
            ny_reg <= py[19];
            rx_reg <= '0;
            ry_reg <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            ax_reg <= {ax_reg[18:0], 1'b0};
            ay_reg <= {ay_reg[18:0], 1'b0};
            rx_reg <= sx[16] ? trx : sx;
            ry_reg <= sy[16] ? try_ : sy;
            qx_reg <= {qx_reg[18:0], ~sx[16]};
            qy_reg <= {qy_reg[18:0], ~sy[16]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // floor correction: negative with remainder takes one more
    always_ff @(posedge clk)
    begin
        if (cmd.div_fix)
        begin
            cx_reg <= nx_reg ? (-$signed({1'b0, qx_reg}) - ((rx_reg != 0) ? 21'sd1 : 21'sd0))
                             : $signed({1'b0, qx_reg});
            cy_reg <= ny_reg ? (-$signed({1'b0, qy_reg}) - ((ry_reg != 0) ? 21'sd1 : 21'sd0))
                             : $signed({1'b0, qy_reg});
        end
    end

    // candidates by column parity
    logic signed [22:0] hr2;
    assign hr2 = {cy_reg[20], cy_reg, 1'b0};
    always_ff @(posedge clk)
    begin
        if (cmd.cand)
        begin
            if (!cx_reg[0])
            begin
                ccol_reg[0] <= 22'(cx_reg);
                chr_reg[0]  <= hr2;
                ccol_reg[1] <= 22'(cx_reg);
                chr_reg[1]  <= hr2 + 23'sd2;
                ccol_reg[2] <= 22'(cx_reg) + 22'sd1;
                chr_reg[2]  <= hr2 + 23'sd1;
            end
            else
            begin
                ccol_reg[0] <= 22'(cx_reg);
                chr_reg[0]  <= hr2 + 23'sd1;
                ccol_reg[1] <= 22'(cx_reg) + 22'sd1;
                chr_reg[1]  <= hr2;
                ccol_reg[2] <= 22'(cx_reg) + 22'sd1;
                chr_reg[2]  <= hr2 + 23'sd2;
            end
        end
    end

    // offsets, products are about 22 by 17 bits
    logic signed [40:0] pcol, phr;
    assign pcol = 41'(ccol_reg[cmd.dsel]) * 41'($signed({1'b0, len}));
    assign phr  = 41'(chr_reg[cmd.dsel]) * 41'($signed({1'b0, wid}));

    always_ff @(posedge clk)
    begin
        if (cmd.meas)
        begin
            dx_reg <= 41'(x_reg) * 41'sd2 - pcol * 41'sd2;
            dy_reg <= 41'(y_reg) * 41'sd2 - phr;
        end
    end

    // squares from registered differences, magnitudes stay at most twice the pitch
    logic [17:0] adx, ady;
    logic [35:0] sqx, sqy;
    logic [63:0] dsq;
    assign adx = dx_reg[40] ? 18'(-dx_reg) : 18'(dx_reg);
    assign ady = dy_reg[40] ? 18'(-dy_reg) : 18'(dy_reg);
    assign sqx = adx * adx;
    assign sqy = ady * ady;
    assign dsq = 64'(sqx) + 64'(sqy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsq_v_reg <= 1'b0;
            dsq_i_reg <= '0;
        end
        else
        begin
            dsq_v_reg <= cmd.meas;
            dsq_i_reg <= cmd.dsel;
        end
    end

    // running minimum, first wins on ties
    always_ff @(posedge clk)
    begin
        if (dsq_v_reg && (dsq_i_reg == 2'd0 || dsq < bestd_reg))
        begin
            bestd_reg <= dsq;
            best_reg  <= dsq_i_reg;
        end
    end

    // table coordinates and range check
    logic signed [22:0] tc, th;
    assign tc = 23'(ccol_reg[best_reg]) + 23'($signed({1'b0, cfg.column_offset}));
    assign th = chr_reg[best_reg] + 23'($signed({1'b0, cfg.row_offset}));

    logic ok;
    assign ok = !tc[22] && (tc < 23'(TABLE_COLUMNS)) && !th[22] && (th < 23'(TABLE_HALF_ROWS));
    assign stat.in_table = ok;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            inreg_reg <= ok;
            tcol_reg  <= tc[COL_BITS-1:0];
            thr_reg   <= th[HR_BITS-1:0];
        end
    end

    // current frame tag and tag clearing pass after reset
    logic [IDX_BITS-1:0] idx, ridx;
    assign idx  = {th[HR_BITS-1:0], tc[COL_BITS-1:0]};
    assign ridx = {thr_reg, tcol_reg};

    assign stat.clr_done = (clr_reg == IDX_BITS'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_cur_reg <= 1'b1;
            clr_reg     <= '0;
        end
        else
        begin
            if (cmd.frame)
            begin
                tag_cur_reg <= ~tag_cur_reg;
            end
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // cell stores and frame tags
    logic [15:0] rtop, rbot, rcnt, ntop, nbot, ncnt;
    logic [IDX_BITS-1:0] addr, tag_addr;
    logic [0:0] tag_rd, tag_wd;
    logic       tag_we, tag_hit;
    assign addr     = cmd.upd ? ridx : idx;
    assign tag_addr = cmd.clr ? clr_reg : addr;
    assign tag_we   = cmd.clr || cmd.upd;
    assign tag_wd   = cmd.clr ? 1'b0 : tag_cur_reg;
    assign tag_hit  = (tag_rd[0] == tag_cur_reg);

    hchb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_top (
        .clk(clk), .we(cmd.upd), .addr(addr), .wdata(ntop), .rdata(rtop));
    hchb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_bot (
        .clk(clk), .we(cmd.upd), .addr(addr), .wdata(nbot), .rdata(rbot));
    hchb_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cnt (
        .clk(clk), .we(cmd.upd), .addr(addr), .wdata(ncnt), .rdata(rcnt));
    hchb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_tag (
        .clk(clk), .we(tag_we), .addr(tag_addr), .wdata(tag_wd), .rdata(tag_rd));

    // merge the point into the cell
    always_comb
    begin
        if (!tag_hit)
        begin
            ntop = z_reg;
            nbot = z_reg;
            ncnt = 16'd1;
        end
        else
        begin
            ntop = (z_reg > $signed(rtop)) ? z_reg : rtop;
            nbot = (z_reg < $signed(rbot)) ? z_reg : rbot;
            ncnt = (rcnt == 16'hFFFF) ? rcnt : rcnt + 16'd1;
        end
    end

    logic [16:0] spread;
    assign spread = 17'($signed(ntop)) - 17'($signed(nbot));

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            top_o_reg <= '0;
            bot_o_reg <= '0;
            cnt_o_reg <= '0;
            obs_reg   <= 1'b0;
        end
        else if (cmd.upd)
        begin
            top_o_reg <= ntop;
            bot_o_reg <= nbot;
            cnt_o_reg <= ncnt;
            obs_reg   <= spread > {1'b0, cfg.height_threshold};
        end
    end

    // result word, zero when outside the table
    assign res = inreg_reg
        ? {1'b0, obs_reg, cnt_o_reg, bot_o_reg, top_o_reg, 7'(thr_reg), 6'(tcol_reg), 1'b1}
        : 64'd0;
endmodule

### design/hchb_checker.sv
// port level checks for the binning block, bound to the top level
module hchb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no input taken in the cycle after one was accepted
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second point taken while busy");

    // dropped point reports all zero fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata == 64'd0)
        else $error("dropped point with nonzero fields");

    // a counted cell holds at least one point
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[61:46] != 16'd0)
        else $error("in-region cell with zero count");
endmodule

bind hex_cell_height_binning_top hchb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

### test/tb.sv
// self-checking bench for the hexagon cell height binning top level
module tb;
    import hchb_pkg::*;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [15:0] z;
        logic               nf;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hex_cell_height_binning_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the registers and the cell table
    logic [15:0]        len_q, wid_q, thr_q;
    logic [7:0]         coff_q, roff_q;
    logic signed [15:0] top_m [DEPTH];
    logic signed [15:0] bot_m [DEPTH];
    logic [15:0]        cnt_m [DEPTH];
    bit                 tag_m [DEPTH];
    bit                 written_m [DEPTH];
    bit                 frame_tag;

    point_t       pending_points[$];
    logic [63:0]  expected_words[$];
    int           errors = 0;
    int           checked = 0;
    int           dropped = 0;
    int           cycles = 0;
    int           seen = 0;
    int           burst_left = 0, gap_left = 0;
    int           hold_left = 0;
    bit           long_hold_done = 0;
    int           accepted = 0;
    longint       win_c, win_r;

    // clock and cycle limit
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1000000)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // nearest centre, as table column and half-row
    function automatic void locate(longint x, longint y, output longint tc, output longint th);
        longint l, w, cx, cy, d, bd, bc, bh;
        longint cc[3];
        longint ch[3];
        l = (len_q == 0) ? 1 : len_q;
        w = (wid_q == 0) ? 1 : wid_q;
        cx = fdiv(x, l);
        cy = fdiv(y, w);
        if (cx[0] == 1'b0)
        begin
            cc[0] = cx;     ch[0] = 2 * cy;
            cc[1] = cx;     ch[1] = 2 * cy + 2;
            cc[2] = cx + 1; ch[2] = 2 * cy + 1;
        end
        else
        begin
            cc[0] = cx;     ch[0] = 2 * cy + 1;
            cc[1] = cx + 1; ch[1] = 2 * cy;
            cc[2] = cx + 1; ch[2] = 2 * cy + 2;
        end
        bd = 0; bc = 0; bh = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = (2 * x - 2 * cc[i] * l) * (2 * x - 2 * cc[i] * l)
              + (2 * y - ch[i] * w) * (2 * y - ch[i] * w);
            if (i == 0 || d < bd)
            begin
                bd = d; bc = cc[i]; bh = ch[i];
            end
        end
        tc = bc + coff_q;
        th = bh + roff_q;
    endfunction

    // bin one point into the shadow table and queue its expected word
    function automatic void bin_point(point_t p);
        longint tc, th, idx, top, bot, cnt;
        bit     inr, tag_after;
        logic [63:0] w;
        locate(p.x, p.y, tc, th);
        inr = (tc >= 0 && tc < TABLE_COLUMNS && th >= 0 && th < TABLE_HALF_ROWS);
        idx = th * TABLE_COLUMNS + tc;
        tag_after = p.nf ? ~frame_tag : frame_tag;
        // never-written cell that would alias valid: choose the other frame bit
        if (inr && !written_m[idx] && tag_after == 1'b0)
            p.nf = ~p.nf;
        if (p.nf)
            frame_tag = ~frame_tag;
        w = '0;
        if (inr)
        begin
            if (tag_m[idx] != frame_tag)
            begin
                top = p.z; bot = p.z; cnt = 1;
                tag_m[idx] = frame_tag;
            end
            else
            begin
                top = top_m[idx]; bot = bot_m[idx]; cnt = cnt_m[idx];
                if (p.z > top) top = p.z;
                if (p.z < bot) bot = p.z;
                if (cnt < 65535) cnt = cnt + 1;
            end
            top_m[idx] = top;
            bot_m[idx] = bot;
            cnt_m[idx] = cnt;
            written_m[idx] = 1;
            w[0]     = 1'b1;
            w[6:1]   = tc[5:0];
            w[13:7]  = th[6:0];
            w[29:14] = top[15:0];
            w[45:30] = bot[15:0];
            w[61:46] = cnt[15:0];
            w[62]    = ((top - bot) > thr_q);
        end
        pending_points.insert(pending_points.size(), p);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic longint clip20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // random point, mostly near the table, seven in ten in a small hot window
    function automatic void random_point();
        point_t p;
        longint l, w, c, r;
        l = (len_q == 0) ? 1 : len_q;
        w = (wid_q == 0) ? 1 : wid_q;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                c = $urandom_range(0, 66) - 2 - longint'(coff_q);
                r = $urandom_range(0, 68) - 2 - longint'(roff_q) / 2;
            end
            2:
            begin
                c = 0; r = 0;
            end
            default:
            begin
                c = win_c + $urandom_range(0, 3);
                r = win_r + $urandom_range(0, 3);
            end
        endcase
        p.x = clip20(c * l + $urandom_range(0, l - 1));
        p.y = clip20(r * w + $urandom_range(0, w - 1));
        if (c == 0 && r == 0)
        begin
            p.x = $urandom;
            p.y = $urandom;
        end
        case ($urandom_range(0, 9))
            0: p.z = 16'sh7fff;
            1: p.z = 16'sh8000;
            2, 3: p.z = $urandom;
            default: p.z = $urandom_range(0, 120) - 60;
        endcase
        p.nf = ($urandom_range(0, 39) == 0);
        bin_point(p);
    endfunction

    function automatic void add_point(longint x, longint y, longint z, bit nf);
        point_t p;
        p.x = x; p.y = y; p.z = z; p.nf = nf;
        bin_point(p);
    endfunction

    // register write: setup cycle then access cycle
    task automatic reg_write(logic [2:0] index, logic [31:0] value);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1; paddr = {index, 2'b00}; pwdata = value;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        case (index)
            REG_CELL_LENGTH: len_q  = value[15:0];
            REG_CELL_WIDTH:  wid_q  = value[15:0];
            REG_THRESHOLD:   thr_q  = value[15:0];
            REG_COL_OFFSET:  coff_q = value[7:0];
            REG_ROW_OFFSET:  roff_q = value[7:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        while (pending_points.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic setup(int l, int w, int t, int co, int ro);
        reg_write(REG_CELL_LENGTH, l);
        reg_write(REG_CELL_WIDTH, w);
        reg_write(REG_THRESHOLD, t);
        reg_write(REG_COL_OFFSET, co);
        reg_write(REG_ROW_OFFSET, ro);
        win_c = $urandom_range(0, 60) - longint'(co);
        win_r = $urandom_range(0, 60) - longint'(ro) / 2;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            random_point();
    endtask

    // count accepted words
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            accepted++;
        end
    end

    // sender: bursts with random gaps, holds a word until taken
    always @(negedge clk)
    begin
        if (s_tvalid && accepted == seen)
        begin
            // word still offered
        end
        else
        begin
            if (accepted != seen)
            begin
                void'(pending_points.pop_front());
                seen = accepted;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 0;
            end
            else if (pending_points.size() != 0)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
                end
                else
                    burst_left--;
                s_tvalid <= 1;
                s_tdata  <= {pending_points[0].z, pending_points[0].y, pending_points[0].x};
                s_tuser  <= pending_points[0].nf;
            end
            else
                s_tvalid <= 0;
        end
    end

    // receiver: random stall pattern plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 0;
        end
        else if (!long_hold_done && accepted >= 300)
        begin
            long_hold_done = 1;
            hold_left = 3000;
            m_tready <= 0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            hold_left = $urandom_range(0, 50);
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 512 < 128);
    end

    // result checker, field by field
    always @(posedge clk)
    begin
        int lo[7];
        int wd[7];
        logic [63:0] got, exp_w;
        bit bad;
        lo = '{0, 1, 7, 14, 30, 46, 62};
        wd = '{1, 6, 7, 16, 16, 16, 1};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                got = m_tdata;
                bad = 0;
                for (int f = 0; f < 7; f++)
                    if (((got >> lo[f]) & ((64'd1 << wd[f]) - 1))
                        != ((exp_w >> lo[f]) & ((64'd1 << wd[f]) - 1)))
                        bad = 1;
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d mismatch: expected %h got %h",
                                 checked, exp_w, got);
                end
                if (!exp_w[0])
                    dropped++;
                checked++;
            end
        end
    end

    // stimulus phases
    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        len_q = 192; wid_q = 222; thr_q = 26; coff_q = 32; roff_q = 64;
        frame_tag = 1;
        for (int i = 0; i < DEPTH; i++)
        begin
            tag_m[i] = 0; written_m[i] = 0;
        end
        win_c = -2; win_r = -2;
        rst_n = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, repeat hits, new frame and stale cells
        add_point(0, 0, 0, 0);
        add_point(5, 7, 100, 0);
        add_point(10, 3, -100, 0);
        add_point(-524288, -524288, -32768, 0);
        add_point(524287, 524287, 32767, 0);
        add_point(-524288, 524287, 0, 0);
        add_point(524287, -524288, 0, 0);
        add_point(0, 0, 32767, 0);
        add_point(0, 0, -32768, 0);
        add_point(1, 1, 20, 1);
        add_point(-1, -1, 5, 0);
        add_point(95, 110, 1, 0);
        add_point(96, 111, 2, 0);
        add_point(0, 0, 3, 1);
        add_point(2, 2, 9, 1);
        add_point(-6144, -7104, 11, 0);
        add_point(6143, 7103, -11, 0);
        run_random(250);
        settle();

        // zero pitch and zero offsets, zero threshold
        setup(0, 0, 0, 0, 0);
        add_point(0, 0, 4, 0);
        add_point(63, 63, 8, 0);
        add_point(-1, 0, 8, 0);
        run_random(150);
        settle();

        // largest pitch and offsets, every point off the table
        setup(65535, 65535, 65535, 255, 255);
        add_point(-524288, -524288, 1, 0);
        add_point(524287, 524287, 1, 1);
        run_random(40);
        settle();

        // random mid pitches
        setup($urandom_range(100, 400), $urandom_range(100, 400), $urandom_range(0, 80),
              $urandom_range(20, 40), $urandom_range(50, 80));
        run_random(400);
        settle();

        // unit pitch and random offsets
        setup(1, 1, $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(120);
        settle();

        // back to reset values
        setup(192, 222, 26, 32, 64);
        run_random(250);
        settle();

        $display("checked %0d results, %0d off the table, over six register settings",
                 checked, dropped);
        $display("included zero and full pitch, frame changes and a long output stall");
        if (errors == 0 && expected_words.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
